[rtl/zvti_pkg.sv]
// ----------------------------------------------------------------------------
// zvti_pkg
// Shared widths, register indexes and types of the zero-velocity
// trapezoid integrator.
// ----------------------------------------------------------------------------
package zvti_pkg;

  localparam int SAMPLE_WIDTH   = 16;  // Q15.0 acceleration sample
  localparam int VELOCITY_WIDTH = 48;  // velocity, 16 fraction bits
  localparam int REG_WIDTH      = 16;  // threshold, still limit, time step
  localparam int RUN_WIDTH      = 16;  // zero-run counter

  localparam int CFG_DATA_WIDTH  = (VELOCITY_WIDTH > REG_WIDTH) ? VELOCITY_WIDTH : REG_WIDTH;
  localparam int CFG_INDEX_WIDTH = 2;

  // magnitude of a sample needs one bit more than the sample
  localparam int MAG_WIDTH  = (SAMPLE_WIDTH + 1 > REG_WIDTH) ? SAMPLE_WIDTH + 1 : REG_WIDTH;
  // prev + cur, then times the unsigned time step (one extra sign bit)
  localparam int SUM_WIDTH  = SAMPLE_WIDTH + 1;
  localparam int PROD_WIDTH = SUM_WIDTH + REG_WIDTH + 1;
  localparam int INC_WIDTH  = PROD_WIDTH - 1;
  localparam int ACC_WIDTH  = ((VELOCITY_WIDTH > INC_WIDTH) ? VELOCITY_WIDTH : INC_WIDTH) + 1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_NOISE_THRESHOLD   = 2'd0,
    REG_STILL_COUNT_LIMIT = 2'd1,
    REG_TIME_STEP         = 2'd2,
    REG_START_VELOCITY    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        [REG_WIDTH-1:0]      noise_threshold;
    logic        [REG_WIDTH-1:0]      still_count_limit;
    logic        [REG_WIDTH-1:0]      time_step;
    logic signed [VELOCITY_WIDTH-1:0] start_velocity;
  } cfg_t;

  // registered input item, noise already cleaned
  typedef struct packed {
    logic                           valid;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           is_zero;
    logic                           first;
  } item_t;

endpackage

[rtl/zvti_in_if.sv]
// ----------------------------------------------------------------------------
// zvti_in_if
// Sample channel: valid/ready handshake with one acceleration sample.
// ----------------------------------------------------------------------------
interface zvti_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [zvti_pkg::SAMPLE_WIDTH-1:0] accel_sample;
  logic                                    first_sample;

  modport source (output valid, output accel_sample, output first_sample, input ready);
  modport sink   (input valid, input accel_sample, input first_sample, output ready);
endinterface

[rtl/zvti_out_if.sv]
// ----------------------------------------------------------------------------
// zvti_out_if
// Result channel: valid/ready handshake with velocity and status flags.
// ----------------------------------------------------------------------------
interface zvti_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [zvti_pkg::VELOCITY_WIDTH-1:0] velocity;
  logic                                      standing_still;
  logic                                      saturated;

  modport source (output valid, output velocity, output standing_still, output saturated,
                  input ready);
  modport sink   (input valid, input velocity, input standing_still, input saturated,
                  output ready);
endinterface

[rtl/zvti_cfg.sv]
// ----------------------------------------------------------------------------
// zvti_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module zvti_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [zvti_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [zvti_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i,
  output zvti_pkg::cfg_t                       cfg_o
);

  zvti_pkg::cfg_t   cfg_q;
  zvti_pkg::cfg_t   cfg_d;
  zvti_pkg::cfg_reg_e reg_sel;

  assign reg_sel = zvti_pkg::cfg_reg_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_sel)
        zvti_pkg::REG_NOISE_THRESHOLD: begin
          cfg_d.noise_threshold = cfg_data_i[zvti_pkg::REG_WIDTH-1:0];
        end
        zvti_pkg::REG_STILL_COUNT_LIMIT: begin
          cfg_d.still_count_limit = cfg_data_i[zvti_pkg::REG_WIDTH-1:0];
        end
        zvti_pkg::REG_TIME_STEP: begin
          cfg_d.time_step = cfg_data_i[zvti_pkg::REG_WIDTH-1:0];
        end
        zvti_pkg::REG_START_VELOCITY: begin
          cfg_d.start_velocity = $signed(cfg_data_i[zvti_pkg::VELOCITY_WIDTH-1:0]);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_threshold   <= '0;
      cfg_q.still_count_limit <= '1;
      cfg_q.time_step         <= '1;
      cfg_q.start_velocity    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/zvti_in_stage.sv]
// ----------------------------------------------------------------------------
// zvti_in_stage
// Input register; cleans samples below the noise threshold to zero.
// ----------------------------------------------------------------------------
module zvti_in_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  zvti_in_if.sink                        in_i,
  input  logic [zvti_pkg::REG_WIDTH-1:0] noise_threshold_i,
  input  logic                           take_i,
  output zvti_pkg::item_t                item_o
);

  logic                                     valid_q;
  logic signed [zvti_pkg::SAMPLE_WIDTH-1:0] sample_q;
  logic                                     is_zero_q;
  logic                                     first_q;

  logic signed [zvti_pkg::MAG_WIDTH-1:0]    sample_ext;
  logic        [zvti_pkg::MAG_WIDTH-1:0]    mag;
  logic                                     below;
  logic                                     accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  // magnitude with one spare bit so the most negative sample stays exact
  assign sample_ext = zvti_pkg::MAG_WIDTH'(in_i.accel_sample);
  assign mag        = sample_ext[zvti_pkg::MAG_WIDTH-1] ? zvti_pkg::MAG_WIDTH'(-sample_ext)
                                                          : zvti_pkg::MAG_WIDTH'(sample_ext);
  assign below      = mag < zvti_pkg::MAG_WIDTH'(noise_threshold_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q  <= below ? '0 : in_i.accel_sample;
      is_zero_q <= below || (in_i.accel_sample == '0);
      first_q   <= in_i.first_sample;
    end
  end

  assign item_o.valid   = valid_q;
  assign item_o.sample  = sample_q;
  assign item_o.is_zero = is_zero_q;
  assign item_o.first   = first_q;

endmodule

[rtl/zvti_update.sv]
// ----------------------------------------------------------------------------
// zvti_update
// Trapezoid step, still detection, saturation and the result register.
// ----------------------------------------------------------------------------
module zvti_update (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  zvti_pkg::item_t item_i,
  input  zvti_pkg::cfg_t  cfg_i,
  output logic            take_o,
  zvti_out_if.source      out_o
);

  localparam int VW = zvti_pkg::VELOCITY_WIDTH;
  localparam int AW = zvti_pkg::ACC_WIDTH;

  // record state
  logic signed [zvti_pkg::SAMPLE_WIDTH-1:0] prev_q;
  logic signed [VW-1:0]                     vel_q, vel_d;
  logic        [zvti_pkg::RUN_WIDTH-1:0]    run_q, run_d;

  // result register
  logic                                     out_valid_q;
  logic signed [VW-1:0]                     out_vel_q;
  logic                                     out_still_q;
  logic                                     out_sat_q;

  logic signed [zvti_pkg::SUM_WIDTH-1:0]    pair_sum;
  logic signed [zvti_pkg::REG_WIDTH:0]      step_s;
  logic signed [zvti_pkg::PROD_WIDTH-1:0]   prod;
  logic signed [zvti_pkg::INC_WIDTH-1:0]    inc;
  logic signed [AW-1:0]                     acc;
  logic        [AW-VW:0]                    acc_top;
  logic                                     ovf;
  logic                                     still;
  logic                                     sat;

  assign take_o = item_i.valid && (!out_valid_q || out_o.ready);

  assign pair_sum = zvti_pkg::SUM_WIDTH'(prev_q) + zvti_pkg::SUM_WIDTH'(item_i.sample);
  assign step_s   = $signed({1'b0, cfg_i.time_step});
  assign prod     = zvti_pkg::PROD_WIDTH'(pair_sum) * zvti_pkg::PROD_WIDTH'(step_s);
  // dropping the low bit of a two's complement value halves toward minus infinity
  assign inc      = prod[zvti_pkg::PROD_WIDTH-1:1];
  assign acc      = AW'(vel_q) + AW'(inc);
  assign acc_top  = acc[AW-1:VW-1];
  assign ovf      = !((&acc_top) || !(|acc_top));

  always_comb begin
    run_d = '0;
    if (!item_i.first && item_i.is_zero) begin
      run_d = (&run_q) ? run_q : run_q + 1'b1;
    end
  end

  assign still = !item_i.first && (run_d > cfg_i.still_count_limit);

  always_comb begin
    sat = 1'b0;
    priority if (item_i.first) begin
      vel_d = cfg_i.start_velocity;
    end else if (still) begin
      vel_d = '0;
    end else if (ovf) begin
      sat   = 1'b1;
      vel_d = acc[AW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      vel_d = acc[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      vel_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        prev_q      <= item_i.sample;
        vel_q       <= vel_d;
        run_q       <= run_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_vel_q   <= vel_d;
      out_still_q <= still;
      out_sat_q   <= sat;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.velocity       = out_vel_q;
  assign out_o.standing_still = out_still_q;
  assign out_o.saturated      = out_sat_q;

endmodule

[rtl/zero_velocity_trapezoid_integrator_core.sv]
// ----------------------------------------------------------------------------
// zero_velocity_trapezoid_integrator_core
// Integrates acceleration samples into a saturated velocity with a
// zero-velocity update after a run of still samples.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. A sample is held in the input
// register until the update stage takes it; that take loads its result into
// the output register, from which the output transfer is made. A new sample
// is taken every cycle while the output side keeps up: the velocity feedback
// (one 17x17 multiply, one wide add and the clip) runs combinationally from
// the velocity register back into it, with no other register in the loop.
// Samples whose magnitude is below noise_threshold count as zero; a
// first_sample transfer loads the start velocity register and restarts the
// record. Registers are written through cfg_we_i / cfg_index_i / cfg_data_i
// and should only change while no transfer is in flight. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module zero_velocity_trapezoid_integrator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  zvti_in_if.sink                              in_i,
  zvti_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic [zvti_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [zvti_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  zvti_pkg::cfg_t  cfg;
  zvti_pkg::item_t item;
  logic            take;

  // register file: threshold, still limit, time step, start velocity
  zvti_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register with noise cleaning; ready follows the update stage
  zvti_in_stage u_in_stage (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_i              (in_i),
    .noise_threshold_i (cfg.noise_threshold),
    .take_i            (take),
    .item_o            (item)
  );

  // trapezoid step, still forcing, clipping and the output register
  zvti_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .cfg_i  (cfg),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule
